### rtl/psd_pkg.sv
// Shared widths, codes and the queue word type for the point-to-segment distance block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package psd_pkg;

  localparam int COORD_BITS = 20;
  localparam int DIFF_W     = COORD_BITS + 1;   // difference of two coordinates
  localparam int PROD_W     = 2 * DIFF_W;       // product of two differences
  localparam int SUM_W      = PROD_W + 1;       // sum of two such products
  localparam int DIST_W     = COORD_BITS + 1;   // distance and square-root width
  localparam int Q_W        = 2 * DIST_W;       // squared distance, divisor, quotient
  localparam int NUM_W      = 2 * Q_W;          // dividend of the interior case
  localparam int REM_W      = DIST_W + 2;       // square-root remainder
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    PART_START  = 2'd0,
    PART_INSIDE = 2'd1,
    PART_END    = 2'd2
  } part_t;

  // One classified item: the result is floor(sqrt(floor(num / den))).
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [Q_W-1:0]   den;
    part_t            part;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/psd_front.sv
// Front end: takes input words, forms the dot, cross and squared lengths, classifies
// the nearest part and builds the dividend/divisor pair. Depends on psd_pkg.
`timescale 1ns / 1ps
module psd_front import psd_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  q_stat_t                      q_stat,
  output logic                         push,
  output job_t                         job
);

  logic en;

  // Stage A: coordinate differences.
  logic a_vld;
  logic signed [DIFF_W-1:0] dx, dy, qx, qy, rx, ry;
  // Stage B: products.
  logic b_vld;
  logic signed [PROD_W-1:0] dxx, dyy, dxqx, dyqy, dxqy, dyqx, qxx, qyy, rxx, ryy;
  // Stage C: classification.
  logic c_vld;
  part_t c_part;
  logic [Q_W-1:0] c_base, c_len2, c_cmag;
  // Stage D: partial squares of the cross magnitude.
  logic d_vld;
  part_t d_part;
  logic [Q_W-1:0] d_base, d_len2, d_hh, d_hl, d_ll;
  // Stage E: finished job.
  logic e_vld;
  job_t e_job;

  logic signed [SUM_W-1:0] len2_s, dot_s, cross_s, s2_s, e2_s, cmag_s;
  part_t part_next;
  logic [Q_W-1:0] base_next;
  logic [NUM_W-1:0] sq_next;

  assign en       = !e_vld || !q_stat.full;
  assign in_ready = en;
  assign push     = e_vld && !q_stat.full;
  assign job      = e_job;

  always_comb begin
    len2_s  = SUM_W'(dxx) + SUM_W'(dyy);
    dot_s   = SUM_W'(dxqx) + SUM_W'(dyqy);
    cross_s = SUM_W'(dxqy) - SUM_W'(dyqx);
    s2_s    = SUM_W'(qxx) + SUM_W'(qyy);
    e2_s    = SUM_W'(rxx) + SUM_W'(ryy);
    cmag_s  = cross_s[SUM_W-1] ? -cross_s : cross_s;
    if (dot_s[SUM_W-1] || (len2_s == '0)) begin
      part_next = PART_START;
      base_next = s2_s[Q_W-1:0];
    end else if (dot_s > len2_s) begin
      part_next = PART_END;
      base_next = e2_s[Q_W-1:0];
    end else begin
      part_next = PART_INSIDE;
      base_next = s2_s[Q_W-1:0];
    end
  end

  assign sq_next = {d_hh, {Q_W{1'b0}}} + (NUM_W'(d_hl) << (DIST_W + 1)) + NUM_W'(d_ll);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= DIFF_W'(end_x)   - DIFF_W'(start_x);
      dy <= DIFF_W'(end_y)   - DIFF_W'(start_y);
      qx <= DIFF_W'(point_x) - DIFF_W'(start_x);
      qy <= DIFF_W'(point_y) - DIFF_W'(start_y);
      rx <= DIFF_W'(point_x) - DIFF_W'(end_x);
      ry <= DIFF_W'(point_y) - DIFF_W'(end_y);

      dxx  <= PROD_W'(dx) * PROD_W'(dx);
      dyy  <= PROD_W'(dy) * PROD_W'(dy);
      dxqx <= PROD_W'(dx) * PROD_W'(qx);
      dyqy <= PROD_W'(dy) * PROD_W'(qy);
      dxqy <= PROD_W'(dx) * PROD_W'(qy);
      dyqx <= PROD_W'(dy) * PROD_W'(qx);
      qxx  <= PROD_W'(qx) * PROD_W'(qx);
      qyy  <= PROD_W'(qy) * PROD_W'(qy);
      rxx  <= PROD_W'(rx) * PROD_W'(rx);
      ryy  <= PROD_W'(ry) * PROD_W'(ry);

      c_part <= part_next;
      c_base <= base_next;
      c_len2 <= len2_s[Q_W-1:0];
      c_cmag <= cmag_s[Q_W-1:0];

      d_part <= c_part;
      d_base <= c_base;
      d_len2 <= c_len2;
      d_hh   <= Q_W'(c_cmag[Q_W-1:DIST_W]) * Q_W'(c_cmag[Q_W-1:DIST_W]);
      d_hl   <= Q_W'(c_cmag[Q_W-1:DIST_W]) * Q_W'(c_cmag[DIST_W-1:0]);
      d_ll   <= Q_W'(c_cmag[DIST_W-1:0]) * Q_W'(c_cmag[DIST_W-1:0]);

      e_job.part <= d_part;
      if (d_part == PART_INSIDE) begin
        e_job.num <= sq_next;
        e_job.den <= d_len2;
      end else begin
        e_job.num <= NUM_W'(d_base);
        e_job.den <= Q_W'(1);
      end
    end
  end

endmodule

### rtl/psd_queue.sv
// Short queue of classified jobs between the front end and the back end.
// Depends on psd_pkg for the job word and status types.
`timescale 1ns / 1ps
module psd_queue import psd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    din,
  input  logic    pop,
  output job_t    dout,
  output q_stat_t stat
);

  job_t mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign dout       = mem[rd_ptr];
  assign stat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

### rtl/psd_back.sv
// Back end: pipelined restoring divider (one quotient bit a stage) followed by a
// pipelined square root (one root bit a stage). Depends on psd_pkg.
`timescale 1ns / 1ps
module psd_back import psd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  job_t              job,
  input  q_stat_t           q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] distance,
  output logic [1:0]        nearest_part
);

  logic en;

  logic           dv_vld  [Q_W+1];
  logic [Q_W-1:0] dv_rem  [Q_W+1];
  logic [Q_W-1:0] dv_lo   [Q_W+1];
  logic [Q_W-1:0] dv_den  [Q_W+1];
  part_t          dv_part [Q_W+1];

  logic              sq_vld  [DIST_W];
  logic [REM_W-1:0]  sq_rem  [DIST_W];
  logic [DIST_W-1:0] sq_root [DIST_W];
  logic [Q_W-1:0]    sq_x    [DIST_W];
  part_t             sq_part [DIST_W];

  assign en  = !sq_vld[DIST_W-1] || out_ready;
  assign pop = en && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0]  <= job.num[NUM_W-1:Q_W];
      dv_lo[0]   <= job.num[Q_W-1:0];
      dv_den[0]  <= job.den;
      dv_part[0] <= job.part;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    logic [Q_W:0] sh, df;
    assign sh = {dv_rem[k], dv_lo[k][Q_W-1]};
    assign df = sh - {1'b0, dv_den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_den[k+1]  <= dv_den[k];
        dv_part[k+1] <= dv_part[k];
        if (!df[Q_W]) begin
          dv_rem[k+1] <= df[Q_W-1:0];
          dv_lo[k+1]  <= {dv_lo[k][Q_W-2:0], 1'b1};
        end else begin
          dv_rem[k+1] <= sh[Q_W-1:0];
          dv_lo[k+1]  <= {dv_lo[k][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  for (genvar j = 0; j < DIST_W; j++) begin : g_sqrt
    logic              vin;
    logic [REM_W-1:0]  rin;
    logic [DIST_W-1:0] tin;
    logic [Q_W-1:0]    xin;
    part_t             pin;
    logic [REM_W-1:0]  cur, trial;
    logic [REM_W:0]    df;

    if (j == 0) begin : g_first
      assign vin = dv_vld[Q_W];
      assign rin = '0;
      assign tin = '0;
      assign xin = dv_lo[Q_W];
      assign pin = dv_part[Q_W];
    end else begin : g_next
      assign vin = sq_vld[j-1];
      assign rin = sq_rem[j-1];
      assign tin = sq_root[j-1];
      assign xin = sq_x[j-1];
      assign pin = sq_part[j-1];
    end

    assign cur   = {rin[REM_W-3:0], xin[Q_W-1:Q_W-2]};
    assign trial = {tin, 2'b01};
    assign df    = {1'b0, cur} - {1'b0, trial};

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[j] <= 1'b0;
      end else if (en) begin
        sq_vld[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_part[j] <= pin;
        sq_x[j]    <= {xin[Q_W-3:0], 2'b00};
        if (!df[REM_W]) begin
          sq_rem[j]  <= df[REM_W-1:0];
          sq_root[j] <= {tin[DIST_W-2:0], 1'b1};
        end else begin
          sq_rem[j]  <= cur;
          sq_root[j] <= {tin[DIST_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid    = sq_vld[DIST_W-1];
  assign distance     = sq_root[DIST_W-1];
  assign nearest_part = sq_part[DIST_W-1];

endmodule

### rtl/point_segment_distance.sv
// Top level of the point-to-segment distance block: front end, job queue, back end.
// Depends on psd_pkg, psd_front, psd_queue and psd_back.
//
//   channel   handshake            payload
//   input     in_valid / in_ready  start_x start_y end_x end_y point_x point_y
//   output    out_valid / out_ready  distance nearest_part
//
// One word is accepted per cycle while the queue has room. A word passes the front-end
// stages A to E and the queue, then 42 divider stages (one quotient bit each) and
// 21 square-root stages (one root bit each).
// Reset clears every valid bit, the queue pointers and count; payload is not reset.
// A stalled output holds the whole back end; the front end keeps filling the
// 4-entry queue and stops only once its last stage holds a word the full queue refuses.
`timescale 1ns / 1ps
module point_segment_distance import psd_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [DIST_W-1:0]            distance,
  output logic [1:0]                   nearest_part
);

  logic    q_push, q_pop;
  job_t    q_din, q_dout;
  q_stat_t q_stat;

  // The front end squares the cross product for interior points, so the back end
  // only ever sees floor(sqrt(floor(num / den))) with den = 1 for the endpoint cases.
  psd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .point_x  (point_x),
    .point_y  (point_y),
    .q_stat   (q_stat),
    .push     (q_push),
    .job      (q_din)
  );

  psd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .stat (q_stat)
  );

  psd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job          (q_dout),
    .q_stat       (q_stat),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .distance     (distance),
    .nearest_part (nearest_part)
  );

  // The front end must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("job queue written while full");

  // The back end must never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_stat.empty))
    else $error("job queue read while empty");

  // After reset no result can be shown.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Input stalls only when the queue is full.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_stat.full)
    else $error("input stalled with room in the queue");

endmodule
